### design/rap_pkg.sv
package rap_pkg;

  // argument count cap, never above what the 8-bit count field holds
  localparam int MAX_ARGS  = 255;
  localparam int COUNT_CAP = (MAX_ARGS > 255) ? 255 : MAX_ARGS;

  // length accumulator width and its widened form for the times-ten step
  localparam int LEN_WIDTH = 24;
  localparam int LEN_EXT_W = LEN_WIDTH + 4;
  localparam int CNT_EXT_W = 12;

  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_CR     = 8'd13;
  localparam logic [7:0] CHAR_LF     = 8'd10;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  typedef logic [LEN_WIDTH-1:0] len_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_EMPTY  = 2'd2
  } rap_kind_t;

  typedef struct packed {
    rap_kind_t  kind;
    logic [7:0] arg_count;
    logic [7:0] data_byte;
    logic [7:0] arg_index;
    logic       last_in_arg;
    logic       last_in_message;
  } rap_result_t;

endpackage

### design/rap_ifs.sv
interface rap_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface rap_out_if;
  logic                 valid;
  logic                 ready;
  rap_pkg::rap_kind_t   kind;
  logic [7:0]           arg_count;
  logic [7:0]           data_byte;
  logic [7:0]           arg_index;
  logic                 last_in_arg;
  logic                 last_in_message;

  modport source (output valid, output kind, output arg_count, output data_byte,
                  output arg_index, output last_in_arg, output last_in_message,
                  input ready);
  modport sink   (input valid, input kind, input arg_count, input data_byte,
                  input arg_index, input last_in_arg, input last_in_message,
                  output ready);
endinterface

### design/resp_array_parser_unit.sv
// channel | dir | word                          | handshake
// in_ch   | in  | in_byte                       | valid/ready, taken when both high
// out_ch  | out | kind, arg_count, data_byte,   | valid/ready, taken when both high
//         |     | arg_index, last_in_arg,       |
//         |     | last_in_message               |
//
// one input word per cycle sustained while out_ch.ready stays high; a result's byte
// passes the input register, then the parser step into the result register
// the parser step is a single small state update per byte, no iteration
// rst_n is synchronous, active low; clears the parser state and both valid flags
// out_ch.ready low holds the result; one more byte waits in the input register,
// and in_ch.ready drops only when both registers are full and the result is not taken
module resp_array_parser_unit (
  input  logic          clk,
  input  logic          rst_n,
  rap_in_if.sink        in_ch,
  rap_out_if.source     out_ch
);

  // input register
  logic                 in_v_r;
  logic [7:0]           in_byte_r;

  // result register
  logic                 out_v_r;
  rap_pkg::rap_result_t out_r;

  // parser step
  logic                 advance;
  logic                 core_valid;
  rap_pkg::rap_result_t core_res;

  // the held byte moves on whenever the result register is free or being drained
  assign advance     = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || advance;

  rap_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_i      (advance),
    .byte_i      (in_byte_r),
    .res_valid_o (core_valid),
    .res_o       (core_res)
  );

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_v_r <= in_ch.valid;
      end
      // a step with no result still frees the slot if the old word was taken
      if (advance) begin
        out_v_r <= core_valid;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.in_byte;
    end
    if (advance && core_valid) begin
      out_r <= core_res;
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.kind            = out_r.kind;
  assign out_ch.arg_count       = out_r.arg_count;
  assign out_ch.data_byte       = out_r.data_byte;
  assign out_ch.arg_index       = out_r.arg_index;
  assign out_ch.last_in_arg     = out_r.last_in_arg;
  assign out_ch.last_in_message = out_r.last_in_message;

  a_held_byte_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !advance) |=> (in_v_r && $stable(in_byte_r)))
    else $error("stalled input byte lost or changed");

  a_result_captured: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && core_valid) |=> out_v_r)
    else $error("parser result not captured");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ch.ready) |=> (out_v_r && $stable(out_r)))
    else $error("stalled result word lost or changed");

endmodule

### design/rap_core.sv
module rap_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_i,
  input  logic [7:0]           byte_i,
  output logic                 res_valid_o,
  output rap_pkg::rap_result_t res_o
);

  typedef enum logic [2:0] {
    PH_WAIT_STAR   = 3'd0,
    PH_COUNT       = 3'd1,
    PH_SEEK_DOLLAR = 3'd2,
    PH_LEN         = 3'd3,
    PH_SKIP_WS     = 3'd4,
    PH_PAYLOAD     = 3'd5,
    PH_DISCARD     = 3'd6
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [7:0]          arg_total_r, arg_total_nxt;
  logic [7:0]          args_done_r, args_done_nxt;
  rap_pkg::len_t       length_acc_r, length_acc_nxt;
  rap_pkg::len_t       bytes_left_r, bytes_left_nxt;

  logic                        is_digit;
  logic                        is_space;
  logic [7:0]                  digit_diff;
  logic [3:0]                  digit;
  logic [rap_pkg::CNT_EXT_W-1:0] cnt_ext;
  logic [rap_pkg::CNT_EXT_W-1:0] cnt_prod;
  logic [7:0]                  cnt_sat;
  logic [rap_pkg::LEN_EXT_W-1:0] len_ext;
  logic [rap_pkg::LEN_EXT_W-1:0] len_prod;
  rap_pkg::len_t               len_sat;
  logic                        last_arg;
  logic                        do_start;
  rap_pkg::len_t               len_dec;
  rap_pkg::len_t               left_dec;
  logic                        hit;
  rap_pkg::rap_result_t        res;

  // character classes and the saturating times-ten accumulators
  always_comb begin
    is_digit   = (byte_i >= rap_pkg::CHAR_ZERO) && (byte_i <= rap_pkg::CHAR_NINE);
    is_space   = (byte_i == rap_pkg::CHAR_CR) || (byte_i == rap_pkg::CHAR_LF) ||
                 (byte_i == rap_pkg::CHAR_SPACE);
    digit_diff = byte_i - rap_pkg::CHAR_ZERO;
    digit      = digit_diff[3:0];

    cnt_ext  = rap_pkg::CNT_EXT_W'(arg_total_r);
    cnt_prod = (cnt_ext << 3) + (cnt_ext << 1) + rap_pkg::CNT_EXT_W'(digit);
    cnt_sat  = (cnt_prod > rap_pkg::CNT_EXT_W'(rap_pkg::COUNT_CAP)) ?
               8'(rap_pkg::COUNT_CAP) : cnt_prod[7:0];

    len_ext  = rap_pkg::LEN_EXT_W'(length_acc_r);
    len_prod = (len_ext << 3) + (len_ext << 1) + rap_pkg::LEN_EXT_W'(digit);
    len_sat  = (len_prod[rap_pkg::LEN_EXT_W-1:rap_pkg::LEN_WIDTH] != '0) ?
               '1 : len_prod[rap_pkg::LEN_WIDTH-1:0];

    last_arg = ({1'b0, args_done_r} + 9'd1) >= {1'b0, arg_total_r};
    len_dec  = length_acc_r - rap_pkg::len_t'(1);
    left_dec = bytes_left_r - rap_pkg::len_t'(1);
  end

  always_comb begin
    phase_nxt      = phase_r;
    arg_total_nxt  = arg_total_r;
    args_done_nxt  = args_done_r;
    length_acc_nxt = length_acc_r;
    bytes_left_nxt = bytes_left_r;
    hit            = 1'b0;
    do_start       = 1'b0;
    res            = '0;

    unique case (phase_r)
      PH_WAIT_STAR: begin
        if (byte_i == rap_pkg::CHAR_STAR) begin
          arg_total_nxt = '0;
          args_done_nxt = '0;
          phase_nxt     = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (is_digit) begin
          arg_total_nxt = cnt_sat;
        end else begin
          // terminator is consumed whatever it is
          args_done_nxt = '0;
          hit           = 1'b1;
          res.kind      = rap_pkg::KIND_HEADER;
          res.arg_count = arg_total_r;
          if (arg_total_r == '0) begin
            res.last_in_message = 1'b1;
            phase_nxt           = PH_WAIT_STAR;
          end else begin
            phase_nxt = PH_SEEK_DOLLAR;
          end
        end
      end
      PH_SEEK_DOLLAR: begin
        if (byte_i == rap_pkg::CHAR_DOLLAR) begin
          length_acc_nxt = '0;
          phase_nxt      = PH_LEN;
        end
      end
      PH_LEN: begin
        if (is_digit) begin
          length_acc_nxt = len_sat;
        end else if (is_space) begin
          phase_nxt = PH_SKIP_WS;
        end else begin
          do_start = 1'b1;
        end
      end
      PH_SKIP_WS: begin
        if (!is_space) begin
          do_start = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        hit            = 1'b1;
        res.kind       = rap_pkg::KIND_DATA;
        res.data_byte  = byte_i;
        res.arg_index  = args_done_r;
        bytes_left_nxt = left_dec;
        if (left_dec == '0) begin
          res.last_in_arg     = 1'b1;
          res.last_in_message = last_arg;
          phase_nxt           = PH_DISCARD;
        end
      end
      PH_DISCARD: begin
        args_done_nxt = args_done_r + 8'd1;
        phase_nxt     = last_arg ? PH_WAIT_STAR : PH_SEEK_DOLLAR;
      end
      default: begin
        phase_nxt = PH_WAIT_STAR;
      end
    endcase

    // first payload byte, or the empty marker for a zero length
    if (do_start) begin
      hit           = 1'b1;
      res.arg_index = args_done_r;
      if (length_acc_r == '0) begin
        res.kind            = rap_pkg::KIND_EMPTY;
        res.last_in_arg     = 1'b1;
        res.last_in_message = last_arg;
        args_done_nxt       = args_done_r + 8'd1;
        phase_nxt           = last_arg ? PH_WAIT_STAR : PH_SEEK_DOLLAR;
      end else begin
        res.kind       = rap_pkg::KIND_DATA;
        res.data_byte  = byte_i;
        bytes_left_nxt = len_dec;
        if (len_dec == '0) begin
          res.last_in_arg     = 1'b1;
          res.last_in_message = last_arg;
          phase_nxt           = PH_DISCARD;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_WAIT_STAR;
      arg_total_r  <= '0;
      args_done_r  <= '0;
      length_acc_r <= '0;
      bytes_left_r <= '0;
    end else if (step_i) begin
      phase_r      <= phase_nxt;
      arg_total_r  <= arg_total_nxt;
      args_done_r  <= args_done_nxt;
      length_acc_r <= length_acc_nxt;
      bytes_left_r <= bytes_left_nxt;
    end
  end

  assign res_valid_o = step_i && hit;
  assign res_o       = res;

  a_payload_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (bytes_left_r != '0))
    else $error("payload phase with no bytes left");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == PH_SEEK_DOLLAR) || (phase_r == PH_LEN) || (phase_r == PH_SKIP_WS) ||
     (phase_r == PH_PAYLOAD) || (phase_r == PH_DISCARD)) |-> (args_done_r < arg_total_r))
    else $error("argument index beyond announced count");

  a_count_starts_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_COUNT) |-> (args_done_r == '0))
    else $error("argument index not cleared while reading count");

endmodule
